FILE: src/aabb_pkg.sv
// Shared types and codes for the box push-out pipeline.
// Used by every module under aabb_point_pushout; depends on nothing.
`timescale 1ns / 1ps

package aabb_pkg;

  localparam int CoordW = 32;
  localparam int AddrW  = 5;

  typedef logic [CoordW-1:0] coord_t;

  // Register map, index = paddr / 4
  typedef enum logic [2:0] {
    REG_BOX_MIN_X = 3'd0,
    REG_BOX_MIN_Y = 3'd1,
    REG_BOX_MIN_Z = 3'd2,
    REG_BOX_MAX_X = 3'd3,
    REG_BOX_MAX_Y = 3'd4,
    REG_BOX_MAX_Z = 3'd5
  } reg_idx_t;

  typedef enum logic [2:0] {
    FACE_NONE = 3'd0,
    FACE_XMIN = 3'd1,
    FACE_XMAX = 3'd2,
    FACE_YMIN = 3'd3,
    FACE_YMAX = 3'd4,
    FACE_ZMIN = 3'd5,
    FACE_ZMAX = 3'd6
  } face_t;

  typedef struct packed {
    coord_t [2:0] lo;
    coord_t [2:0] hi;
  } box_t;

  // After stage 1: point, inside flag, distances to min/max faces per axis
  typedef struct packed {
    coord_t [2:0] pt;
    logic         in_box;
    coord_t [2:0] dist_lo;
    coord_t [2:0] dist_hi;
  } dist_t;

  // After stage 2: nearest face per axis
  typedef struct packed {
    coord_t [2:0] pt;
    logic         in_box;
    coord_t [2:0] best;
    logic   [2:0] pick_hi;
  } pair_t;

  // Final result
  typedef struct packed {
    coord_t [2:0] pt;
    logic         in_box;
    face_t        face;
  } res_t;

endpackage

FILE: src/aabb_regs.sv
// Configuration register file for the box bounds, APB-style access.
// Depends on aabb_pkg.
`timescale 1ns / 1ps

module aabb_regs (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     cfg_psel,
  input  logic                     cfg_penable,
  input  logic                     cfg_pwrite,
  input  logic [aabb_pkg::AddrW-1:0] cfg_paddr,
  input  logic [31:0]              cfg_pwdata,
  output logic [31:0]              cfg_prdata,
  output logic                     cfg_pready,
  output aabb_pkg::box_t           box
);

  aabb_pkg::box_t box_r;
  aabb_pkg::box_t box_nxt;
  aabb_pkg::reg_idx_t idx;
  logic wr_en;

  assign cfg_pready = 1'b1;
  assign idx   = aabb_pkg::reg_idx_t'(cfg_paddr[aabb_pkg::AddrW-1:2]);
  assign wr_en = cfg_psel && cfg_penable && cfg_pwrite;

  always_comb begin
    box_nxt = box_r;
    if (wr_en) begin
      unique case (idx)
        aabb_pkg::REG_BOX_MIN_X: box_nxt.lo[0] = cfg_pwdata;
        aabb_pkg::REG_BOX_MIN_Y: box_nxt.lo[1] = cfg_pwdata;
        aabb_pkg::REG_BOX_MIN_Z: box_nxt.lo[2] = cfg_pwdata;
        aabb_pkg::REG_BOX_MAX_X: box_nxt.hi[0] = cfg_pwdata;
        aabb_pkg::REG_BOX_MAX_Y: box_nxt.hi[1] = cfg_pwdata;
        aabb_pkg::REG_BOX_MAX_Z: box_nxt.hi[2] = cfg_pwdata;
        default: ; // drop writes past the last register
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      aabb_pkg::REG_BOX_MIN_X: cfg_prdata = box_r.lo[0];
      aabb_pkg::REG_BOX_MIN_Y: cfg_prdata = box_r.lo[1];
      aabb_pkg::REG_BOX_MIN_Z: cfg_prdata = box_r.lo[2];
      aabb_pkg::REG_BOX_MAX_X: cfg_prdata = box_r.hi[0];
      aabb_pkg::REG_BOX_MAX_Y: cfg_prdata = box_r.hi[1];
      aabb_pkg::REG_BOX_MAX_Z: cfg_prdata = box_r.hi[2];
      default:                 cfg_prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      box_r <= '0;
    end else begin
      box_r <= box_nxt;
    end
  end

  assign box = box_r;

endmodule

FILE: src/aabb_dist.sv
// Stage 1: 33-bit differences to each face, strict inside test.
// Depends on aabb_pkg.
`timescale 1ns / 1ps

module aabb_dist (
  input  logic                    clk,
  input  logic                    rst_n,
  input  aabb_pkg::box_t          box,
  input  logic                    valid_i,
  input  aabb_pkg::coord_t [2:0]  pt_i,
  output logic                    ready_o,
  output logic                    valid_o,
  output aabb_pkg::dist_t         data_o,
  input  logic                    ready_i
);

  logic            valid_r;
  aabb_pkg::dist_t data_r;
  aabb_pkg::dist_t data_nxt;
  logic [32:0]     diff_lo [3];
  logic [32:0]     diff_hi [3];
  logic [2:0]      axis_in;

  always_comb begin
    data_nxt.pt = pt_i;
    for (int a = 0; a < 3; a++) begin
      diff_lo[a] = {pt_i[a][31], pt_i[a]} - {box.lo[a][31], box.lo[a]};
      diff_hi[a] = {box.hi[a][31], box.hi[a]} - {pt_i[a][31], pt_i[a]};
      // strictly positive on both sides
      axis_in[a] = !diff_lo[a][32] && (|diff_lo[a]) && !diff_hi[a][32] && (|diff_hi[a]);
      data_nxt.dist_lo[a] = diff_lo[a][31:0];
      data_nxt.dist_hi[a] = diff_hi[a][31:0];
    end
    data_nxt.in_box = &axis_in;
  end

  assign ready_o = !valid_r || ready_i;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (ready_o) begin
      valid_r <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    if (ready_o && valid_i) begin
      data_r <= data_nxt;
    end
  end

  assign valid_o = valid_r;
  assign data_o  = data_r;

endmodule

FILE: src/aabb_pair.sv
// Stage 2: nearer of the min and max face on each axis.
// Depends on aabb_pkg.
`timescale 1ns / 1ps

module aabb_pair (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            valid_i,
  input  aabb_pkg::dist_t data_i,
  output logic            ready_o,
  output logic            valid_o,
  output aabb_pkg::pair_t data_o,
  input  logic            ready_i
);

  logic            valid_r;
  aabb_pkg::pair_t data_r;
  aabb_pkg::pair_t data_nxt;

  always_comb begin
    data_nxt.pt     = data_i.pt;
    data_nxt.in_box = data_i.in_box;
    for (int a = 0; a < 3; a++) begin
      // min face wins a tie
      data_nxt.pick_hi[a] = data_i.dist_hi[a] < data_i.dist_lo[a];
      data_nxt.best[a]    = data_nxt.pick_hi[a] ? data_i.dist_hi[a] : data_i.dist_lo[a];
    end
  end

  assign ready_o = !valid_r || ready_i;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (ready_o) begin
      valid_r <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    if (ready_o && valid_i) begin
      data_r <= data_nxt;
    end
  end

  assign valid_o = valid_r;
  assign data_o  = data_r;

endmodule

FILE: src/aabb_resolve.sv
// Stage 3: pick the nearest axis, snap that coordinate to the face if inside, hold the result.
// Depends on aabb_pkg.
`timescale 1ns / 1ps

module aabb_resolve (
  input  logic            clk,
  input  logic            rst_n,
  input  aabb_pkg::box_t  box,
  input  logic            valid_i,
  input  aabb_pkg::pair_t data_i,
  output logic            ready_o,
  output logic            valid_o,
  output aabb_pkg::res_t  data_o,
  input  logic            ready_i
);

  logic             valid_r;
  aabb_pkg::res_t   data_r;
  aabb_pkg::res_t   data_nxt;
  logic [1:0]       axis;
  aabb_pkg::coord_t best_xy;
  logic             hi_sel;

  always_comb begin
    // earlier axis wins a tie
    axis    = (data_i.best[1] < data_i.best[0]) ? 2'd1 : 2'd0;
    best_xy = data_i.best[axis];
    if (data_i.best[2] < best_xy) begin
      axis = 2'd2;
    end
    hi_sel = data_i.pick_hi[axis];

    data_nxt.pt     = data_i.pt;
    data_nxt.in_box = data_i.in_box;
    data_nxt.face   = aabb_pkg::FACE_NONE;
    if (data_i.in_box) begin
      data_nxt.pt[axis] = hi_sel ? box.hi[axis] : box.lo[axis];
      case ({axis, hi_sel})
        3'b000:  data_nxt.face = aabb_pkg::FACE_XMIN;
        3'b001:  data_nxt.face = aabb_pkg::FACE_XMAX;
        3'b010:  data_nxt.face = aabb_pkg::FACE_YMIN;
        3'b011:  data_nxt.face = aabb_pkg::FACE_YMAX;
        3'b100:  data_nxt.face = aabb_pkg::FACE_ZMIN;
        3'b101:  data_nxt.face = aabb_pkg::FACE_ZMAX;
        default: data_nxt.face = aabb_pkg::FACE_NONE;
      endcase
    end
  end

  assign ready_o = !valid_r || ready_i;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (ready_o) begin
      valid_r <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    if (ready_o && valid_i) begin
      data_r <= data_nxt;
    end
  end

  assign valid_o = valid_r;
  assign data_o  = data_r;

endmodule

FILE: src/aabb_point_pushout.sv
// Push a point out of an axis-aligned box: three-stage pipeline.
//
// Input stream in_*: one point per request, x/y/z signed Q16.16 in in_tdata.
// Output stream out_*: the resolved point in out_tdata, the inside flag and
// the face code in out_tuser. One result leaves for every point taken, in order.
// Box bounds sit in six registers on the cfg_* port (min x/y/z, then max
// x/y/z at byte addresses 0..20); write them only while the pipe is empty.
// A point taken passes through the distance stage, the per-axis compare
// stage and the nearest-face/snap stage, each registered, before it raises
// out_tvalid. Throughput: one point per cycle while out_tready stays high,
// set by the per-stage register handoff.
// Each stage takes a new request whenever it is empty or its successor takes
// its current one, so bubbles close up while the receiver stalls; a stalled
// result holds on out_tdata/out_tuser until out_tready.
// Reset (rst_n low, synchronous) empties all stages and clears the box to 0.
// Depends on aabb_pkg, aabb_regs, aabb_dist, aabb_pair, aabb_resolve.
`timescale 1ns / 1ps

module aabb_point_pushout (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [95:0] in_tdata,   // point_x[31:0], point_y[63:32], point_z[95:64]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [95:0] out_tdata,  // out_x[31:0], out_y[63:32], out_z[95:64]
  output logic [3:0]  out_tuser,  // was_inside[0], face_hit[3:1]
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [aabb_pkg::AddrW-1:0] cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  aabb_pkg::box_t               box;
  aabb_pkg::coord_t [2:0]       pt_in;
  logic                         s1_valid;
  logic                         s1_ready;
  aabb_pkg::dist_t              s1_data;
  logic                         s2_valid;
  logic                         s2_ready;
  aabb_pkg::pair_t              s2_data;
  aabb_pkg::res_t               res;

  assign pt_in = in_tdata;

  aabb_regs u_regs (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .box         (box)
  );

  aabb_dist u_dist (
    .clk     (clk),
    .rst_n   (rst_n),
    .box     (box),
    .valid_i (in_tvalid),
    .pt_i    (pt_in),
    .ready_o (in_tready),
    .valid_o (s1_valid),
    .data_o  (s1_data),
    .ready_i (s1_ready)
  );

  aabb_pair u_pair (
    .clk     (clk),
    .rst_n   (rst_n),
    .valid_i (s1_valid),
    .data_i  (s1_data),
    .ready_o (s1_ready),
    .valid_o (s2_valid),
    .data_o  (s2_data),
    .ready_i (s2_ready)
  );

  aabb_resolve u_resolve (
    .clk     (clk),
    .rst_n   (rst_n),
    .box     (box),
    .valid_i (s2_valid),
    .data_i  (s2_data),
    .ready_o (s2_ready),
    .valid_o (out_tvalid),
    .data_o  (res),
    .ready_i (out_tready)
  );

  assign out_tdata = res.pt;
  assign out_tuser = {res.face, res.in_box};

endmodule
